// File: src/pvq_pkg.sv
`timescale 1ns / 1ps

package pvq_pkg;

   // Default number of descriptor slots.
   localparam int QUEUE_DEPTH_DEF = 24;

   // Width of the reported entry count.
   localparam int COUNT_W = 5;

   // Operation codes.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Priority codes.
   localparam logic [1:0] PRIO_LOW    = 2'd0;
   localparam logic [1:0] PRIO_MEDIUM = 2'd1;
   localparam logic [1:0] PRIO_HIGH   = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_APPENDED = 3'd0;
   localparam logic [2:0] STATUS_REPLACED = 3'd1;
   localparam logic [2:0] STATUS_DROPPED  = 3'd2;
   localparam logic [2:0] STATUS_POPPED   = 3'd3;
   localparam logic [2:0] STATUS_EMPTY    = 3'd4;

   // One request word.
   typedef struct packed {
      logic        func;
      logic [1:0]  priority_req;
      logic [15:0] packet_tag;
      logic [9:0]  pkt_bytes;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        out_tag;
      logic [9:0]         out_size;
      logic [1:0]         out_priority;
      logic [COUNT_W-1:0] queue_count;
      logic [31:0]        drop_count;
   } rsp_type;

   // One stored descriptor.
   typedef struct packed {
      logic [15:0] tag;
      logic [9:0]  size;
      logic [1:0]  prio;
   } entry_type;

   // Completion event from the sequencer to the output stage.
   typedef struct packed {
      logic               valid;
      logic               bump;
      logic [2:0]         status;
      logic [15:0]        tag;
      logic [9:0]         size;
      logic [1:0]         prio;
      logic [COUNT_W-1:0] count;
   } event_type;

endpackage

// File: src/pvq_store.sv
`timescale 1ns / 1ps

module pvq_store #(
   parameter int QUEUE_DEPTH = pvq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                                clock,
   input  logic                                                wr_en,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] wr_addr,
   input  pvq_pkg::entry_type                                  wr_entry,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_addr,
   output pvq_pkg::entry_type                                  rd_entry
);

   // Descriptor memory with one write port and one registered read port.
   pvq_pkg::entry_type mem_ff [QUEUE_DEPTH];
   pvq_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_ff;

endmodule

// File: src/pvq_ctrl.sv
`timescale 1ns / 1ps

module pvq_ctrl #(
   parameter int QUEUE_DEPTH = pvq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  pvq_pkg::req_type                                    req,
   output logic                                                busy,
   output pvq_pkg::event_type                                  evt,
   output logic                                                wr_en,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] wr_addr,
   output pvq_pkg::entry_type                                  wr_entry,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_addr,
   input  pvq_pkg::entry_type                                  rd_entry
);

   localparam int SlotW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CountW = pvq_pkg::COUNT_W;
   localparam logic [SlotW-1:0] LastSlot  = SlotW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0]  FullCount = CntW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [SlotW-1:0]   head_ff, head_in;
   logic [SlotW-1:0]   tail_ff, tail_in;
   logic [SlotW-1:0]   idx_ff, idx_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    left_ff, left_in;
   pvq_pkg::entry_type hold_ff, hold_in;
   pvq_pkg::entry_type new_entry;
   logic [SlotW-1:0]   step_in;
   logic [SlotW-1:0]   step_out;

   // Incoming descriptor with priority three folded onto high.
   always_comb begin
      new_entry.tag  = req.packet_tag;
      new_entry.size = req.pkt_bytes;
      new_entry.prio = (req.priority_req > pvq_pkg::PRIO_HIGH) ?
                       pvq_pkg::PRIO_HIGH : req.priority_req;
   end

   // Shared slot stepper: advances tail, head or the scan index in turn.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: step_in = tail_ff;
         ST_POP:  step_in = head_ff;
         ST_SCAN: step_in = idx_ff;
         default: step_in = tail_ff;
      endcase
   end

   assign step_out = (step_in == LastSlot) ? '0 : step_in + 1'b1;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      left_in  = left_ff;
      hold_in  = hold_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      wr_entry = new_entry;
      rd_addr  = head_ff;
      evt      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req.func == pvq_pkg::FUNC_POP) begin
                  if (count_ff == '0) begin
                     evt.valid  = 1'b1;
                     evt.status = pvq_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = ST_POP;
                  end
               end else if (count_ff != FullCount) begin
                  wr_en      = 1'b1;
                  tail_in    = step_out;
                  count_in   = count_ff + 1'b1;
                  evt.valid  = 1'b1;
                  evt.status = pvq_pkg::STATUS_APPENDED;
               end else begin
                  // Full: every such push counts, whether it evicts or not.
                  evt.bump = 1'b1;
                  if (new_entry.prio == pvq_pkg::PRIO_LOW) begin
                     evt.valid  = 1'b1;
                     evt.status = pvq_pkg::STATUS_DROPPED;
                  end else begin
                     hold_in  = new_entry;
                     idx_in   = head_ff;
                     left_in  = count_ff;
                     state_in = ST_SCAN;
                  end
               end
            end
         end

         ST_POP: begin
            head_in    = step_out;
            count_in   = count_ff - 1'b1;
            evt.valid  = 1'b1;
            evt.status = pvq_pkg::STATUS_POPPED;
            evt.tag    = rd_entry.tag;
            evt.size   = rd_entry.size;
            evt.prio   = rd_entry.prio;
            state_in   = ST_IDLE;
         end

         ST_SCAN: begin
            // The slot read last cycle is checked while the next one is fetched.
            rd_addr = step_out;
            if (rd_entry.prio == pvq_pkg::PRIO_LOW) begin
               wr_en      = 1'b1;
               wr_addr    = idx_ff;
               wr_entry   = hold_ff;
               evt.valid  = 1'b1;
               evt.status = pvq_pkg::STATUS_REPLACED;
               state_in   = ST_IDLE;
            end else if (left_ff == CntW'(1)) begin
               evt.valid  = 1'b1;
               evt.status = pvq_pkg::STATUS_DROPPED;
               state_in   = ST_IDLE;
            end else begin
               idx_in  = step_out;
               left_in = left_ff - 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      evt.count = CountW'(count_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Scan registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      left_ff <= left_in;
      hold_ff <= hold_in;
   end

   assign busy = reset || (state_ff != ST_IDLE);

endmodule

// File: src/priority_evicting_packet_queue.sv
`timescale 1ns / 1ps

// Priority-evicting descriptor queue. A word is taken when start is high
// and busy is low; its response appears on rsp_data for exactly one cycle
// with rsp_strobe, and cannot be held off, so it must be captured then.
// Appends, pops of an empty queue and low-priority pushes into a full queue
// respond in the cycle after acceptance; the next word may follow at once.
// A pop is answered from the ST_POP state through the response register,
// since the head descriptor is fetched through the registered read port of
// the descriptor memory. A medium or high push into a full queue walks the
// slots from the head, one slot per cycle through that same read port and
// the shared slot stepper; busy stays high meanwhile.
module priority_evicting_packet_queue #(
   parameter int QUEUE_DEPTH = pvq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pvq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pvq_pkg::rsp_type rsp_data
);

   localparam int SlotW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   pvq_pkg::event_type evt;
   logic               wr_en;
   logic [SlotW-1:0]   wr_addr;
   pvq_pkg::entry_type wr_entry;
   logic [SlotW-1:0]   rd_addr;
   pvq_pkg::entry_type rd_entry;

   logic               rsp_strobe_ff;
   pvq_pkg::rsp_type   rsp_ff, rsp_in;
   logic [31:0]        drop_ff, drop_in;

   pvq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .busy     (busy),
      .evt      (evt),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   pvq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   // Wrapping drop counter and the response word it feeds.
   always_comb begin
      drop_in             = drop_ff + {31'd0, evt.bump};
      rsp_in.status       = evt.status;
      rsp_in.out_tag      = evt.tag;
      rsp_in.out_size     = evt.size;
      rsp_in.out_priority = evt.prio;
      rsp_in.queue_count  = evt.count;
      rsp_in.drop_count   = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         drop_ff       <= '0;
      end else begin
         rsp_strobe_ff <= evt.valid;
         drop_ff       <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // An empty pop reports no entries and no descriptor.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == pvq_pkg::STATUS_EMPTY) |->
      (rsp_data.queue_count == '0) && (rsp_data.out_tag == '0) &&
      (rsp_data.out_size == '0) && (rsp_data.out_priority == '0))
      else $error("empty pop reported data or a nonzero count");

   // An eviction only happens in a full queue.
   a_replace_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == pvq_pkg::STATUS_REPLACED) |->
      (rsp_data.queue_count == pvq_pkg::COUNT_W'(QUEUE_DEPTH)))
      else $error("replacement reported in a queue that was not full");

   // Stored priorities are always folded, so a popped one is never three.
   a_pop_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == pvq_pkg::STATUS_POPPED) |->
      (rsp_data.out_priority <= pvq_pkg::PRIO_HIGH))
      else $error("popped descriptor carries an unfolded priority");

endmodule

// File: test/priority_evicting_packet_queue_test.sv
`timescale 1ns / 1ps

module priority_evicting_packet_queue_test;

   localparam int DEPTH       = pvq_pkg::QUEUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = DEPTH + 8;

   // Priority value above high, which the queue folds onto high.
   localparam logic [1:0] PRIO_OVER_HIGH = 2'd3;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   pvq_pkg::req_type req_data;
   logic             rsp_strobe;
   pvq_pkg::rsp_type rsp_data;

   // Shadow copy of the descriptor ring, updated as each word is accepted.
   pvq_pkg::entry_type shadow_slots [DEPTH];
   int unsigned        shadow_head;
   int unsigned        shadow_tail;
   int unsigned        shadow_held;
   logic [31:0]        shadow_drops;

   // Responses that the queue still owes, oldest first.
   pvq_pkg::rsp_type owed_responses[$];
   pvq_pkg::rsp_type oldest_owed;

   int unsigned failures    = 0;
   int unsigned words_sent  = 0;
   int unsigned cycle_count = 0;
   int unsigned status_seen [8];

   // Sender burst state.
   int unsigned burst_left = 0;
   int unsigned gap_max    = 0;

   priority_evicting_packet_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Free-running clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("priority_evicting_packet_queue_test failed");
         $finish;
      end
   end

   function automatic int unsigned step_slot(input int unsigned slot);
      return (slot + 1 >= DEPTH) ? 0 : slot + 1;
   endfunction

   // Computes the response to one word and advances the shadow ring.
   function automatic pvq_pkg::rsp_type predict_queue_response(input pvq_pkg::req_type w);
      pvq_pkg::rsp_type r;
      logic [1:0]       p;
      int unsigned      idx;
      bit               found;
      r = '0;
      p = (w.priority_req > pvq_pkg::PRIO_HIGH) ? pvq_pkg::PRIO_HIGH : w.priority_req;
      if (w.func == pvq_pkg::FUNC_PUSH) begin
         if (shadow_held < DEPTH) begin
            shadow_slots[shadow_tail] = '{w.packet_tag, w.pkt_bytes, p};
            shadow_tail = step_slot(shadow_tail);
            shadow_held++;
            r.status = pvq_pkg::STATUS_APPENDED;
         end else begin
            // A full queue drops or overwrites; either way the counter moves.
            shadow_drops = shadow_drops + 1;
            r.status = pvq_pkg::STATUS_DROPPED;
            if (p != pvq_pkg::PRIO_LOW) begin
               idx = shadow_head;
               found = 1'b0;
               for (int n = 0; n < shadow_held && !found; n++) begin
                  if (shadow_slots[idx].prio == pvq_pkg::PRIO_LOW) begin
                     shadow_slots[idx] = '{w.packet_tag, w.pkt_bytes, p};
                     r.status = pvq_pkg::STATUS_REPLACED;
                     found = 1'b1;
                  end
                  idx = step_slot(idx);
               end
            end
         end
      end else if (shadow_held == 0) begin
         r.status = pvq_pkg::STATUS_EMPTY;
      end else begin
         r.status       = pvq_pkg::STATUS_POPPED;
         r.out_tag      = shadow_slots[shadow_head].tag;
         r.out_size     = shadow_slots[shadow_head].size;
         r.out_priority = shadow_slots[shadow_head].prio;
         shadow_head    = step_slot(shadow_head);
         shadow_held--;
      end
      r.queue_count = shadow_held[pvq_pkg::COUNT_W-1:0];
      r.drop_count  = shadow_drops;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // Every response word is matched against the oldest owed one.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (owed_responses.size() == 0) begin
            $error("response word with nothing owed: %p", rsp_data);
            failures++;
         end else begin
            oldest_owed = owed_responses.pop_front();
            check_field("status", 32'(oldest_owed.status), 32'(rsp_data.status));
            check_field("out_tag", 32'(oldest_owed.out_tag), 32'(rsp_data.out_tag));
            check_field("out_size", 32'(oldest_owed.out_size), 32'(rsp_data.out_size));
            check_field("out_priority", 32'(oldest_owed.out_priority),
                        32'(rsp_data.out_priority));
            check_field("queue_count", 32'(oldest_owed.queue_count),
                        32'(rsp_data.queue_count));
            check_field("drop_count", oldest_owed.drop_count, rsp_data.drop_count);
            status_seen[rsp_data.status]++;
         end
      end
   end

   // Sends one word in bursts with random gaps, holding it until taken.
   task automatic send_word(input pvq_pkg::req_type w);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      owed_responses.push_back(predict_queue_response(w));
      words_sent++;
   endtask

   task automatic push_word(input logic [1:0] prio, input logic [15:0] tag,
                            input logic [9:0] size);
      pvq_pkg::req_type w;
      w.func         = pvq_pkg::FUNC_PUSH;
      w.priority_req = prio;
      w.packet_tag   = tag;
      w.pkt_bytes    = size;
      send_word(w);
   endtask

   // A pop carries random content in the fields that it ignores.
   task automatic pop_word();
      pvq_pkg::req_type w;
      w.func         = pvq_pkg::FUNC_POP;
      w.priority_req = 2'($urandom_range(0, 3));
      w.packet_tag   = 16'($urandom);
      w.pkt_bytes    = 10'($urandom);
      send_word(w);
   endtask

   function automatic logic [15:0] random_tag();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [9:0] random_size();
      case ($urandom_range(0, 9))
         0: return 10'h000;
         1: return 10'h3ff;
         default: return 10'($urandom);
      endcase
   endfunction

   task automatic push_random(input int unsigned low_pct);
      logic [1:0] p;
      if ($urandom_range(1, 100) <= low_pct)
         p = pvq_pkg::PRIO_LOW;
      else
         p = 2'($urandom_range(1, 3));
      push_word(p, random_tag(), random_size());
   endtask

   // Field extremes, every operation, priority three and the empty pop.
   task automatic test_directed_corners();
      gap_max = 0;
      pop_word();
      push_word(pvq_pkg::PRIO_LOW, 16'h0000, 10'h000);
      push_word(pvq_pkg::PRIO_MEDIUM, 16'hffff, 10'h3ff);
      push_word(pvq_pkg::PRIO_HIGH, 16'h5a5a, 10'h155);
      push_word(PRIO_OVER_HIGH, 16'ha5a5, 10'h2aa);
      repeat (4) pop_word();
      pop_word();
      push_word(PRIO_OVER_HIGH, 16'h8001, 10'h201);
      pop_word();
   endtask

   // Fill the ring, overload it with mixed priorities, then drain part or all of it.
   task automatic test_eviction_rounds(input int unsigned rounds);
      int unsigned low_pct;
      int unsigned pops;
      repeat (rounds) begin
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         low_pct = $urandom_range(0, 100);
         while (shadow_held < DEPTH)
            push_random(low_pct);
         repeat ($urandom_range(1, 12))
            push_random($urandom_range(0, 60));
         pops = $urandom_range(1, shadow_held + 2);
         repeat (pops) pop_word();
      end
   endtask

   // A full ring with no low entries forces the longest scan and a drop.
   task automatic test_full_without_low(input int unsigned rounds);
      repeat (rounds) begin
         gap_max = $urandom_range(0, 4);
         while (shadow_held < DEPTH)
            push_random(0);
         repeat ($urandom_range(3, 8))
            push_random(25);
         while (shadow_held > 0)
            pop_word();
         pop_word();
      end
   endtask

   // Mixed traffic whose push share changes from phase to phase.
   task automatic test_random_traffic(input int unsigned words);
      int unsigned push_pct;
      int unsigned phase_left;
      phase_left = 0;
      push_pct   = 50;
      repeat (words) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 80);
            push_pct   = $urandom_range(25, 85);
            gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
         phase_left--;
         if ($urandom_range(1, 100) <= push_pct)
            push_random($urandom_range(10, 70));
         else
            pop_word();
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      shadow_head   = 0;
      shadow_tail   = 0;
      shadow_held   = 0;
      shadow_drops  = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_eviction_rounds(20);
      test_full_without_low(3);
      test_random_traffic(950);

      @(negedge clock);
      start <= 1'b0;
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d words; responses: %0d appended, %0d replaced, %0d dropped,",
               words_sent, status_seen[pvq_pkg::STATUS_APPENDED],
               status_seen[pvq_pkg::STATUS_REPLACED], status_seen[pvq_pkg::STATUS_DROPPED]);
      $display("%0d popped, %0d empty pops; %0d mismatches in %0d cycles.",
               status_seen[pvq_pkg::STATUS_POPPED], status_seen[pvq_pkg::STATUS_EMPTY],
               failures, cycle_count);
      if (failures == 0)
         $display("priority_evicting_packet_queue_test passed");
      else
         $display("priority_evicting_packet_queue_test failed");
      $finish;
   end

endmodule

// File: priority_evicting_packet_queue.f
src/pvq_pkg.sv
src/pvq_store.sv
src/pvq_ctrl.sv
src/priority_evicting_packet_queue.sv
test/priority_evicting_packet_queue_test.sv
